/* src/homomorphic_filter_gain_core_macros.svh */
// Assertion macros for the homomorphic filter gain core.
// Taken in by the checker; no other dependencies.
`ifndef HOMOMORPHIC_FILTER_GAIN_CORE_MACROS_SVH
`define HOMOMORPHIC_FILTER_GAIN_CORE_MACROS_SVH

// checked only outside reset
`define HFG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define HFG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/hfg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants of the homomorphic filter gain core.
// No dependencies.
package hfg_pkg;

    localparam int unsigned HFG_MAX_DIM        = 1024;
    localparam int unsigned HFG_GAIN_FRAC_BITS = 11;

    localparam int unsigned HFG_NUM_W  = 26;   // slope * dist2
    localparam int unsigned HFG_DEN_W  = 12;   // cutoff_radius squared
    localparam int unsigned HFG_FRAC_W = 32;
    localparam int unsigned HFG_QUO_W  = HFG_NUM_W + HFG_FRAC_W;
    localparam int unsigned HFG_DIV_STEP = 4;

    localparam int unsigned HFG_SER_TERMS  = 16;
    localparam int unsigned HFG_ZERO_LIMIT = 12;
    localparam int unsigned HFG_POW_STAGES = HFG_ZERO_LIMIT - 1;

    typedef enum logic [2:0] {
        CFG_GAMMA_HIGH    = 3'd0,
        CFG_GAMMA_LOW     = 3'd1,
        CFG_CUTOFF_RADIUS = 3'd2,
        CFG_SLOPE         = 3'd3,
        CFG_PLANE_ROWS    = 3'd4,
        CFG_PLANE_COLS    = 3'd5
    } t_cfg_index;

    // series state travelling down the exp(-f) pipeline
    typedef struct packed {
        logic        vld;
        logic        big;
        logic [3:0]  k;
        logic [31:0] f;
        logic [32:0] term;
        logic [34:0] pos;
        logic [33:0] neg;
    } t_ser;

    // state of the exp(-1) power stages
    typedef struct packed {
        logic        vld;
        logic        big;
        logic [3:0]  k;
        logic [32:0] e;
    } t_pow;

    // exp(-1) in Q0.32: series at one half, squared, all truncating
    function automatic logic [31:0] f_exp_neg_one();
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] half;
        logic [63:0] sq;
        term = 64'h1_0000_0000;
        pos  = 64'h1_0000_0000;
        neg  = 64'd0;
        for (int n = 1; n <= int'(HFG_SER_TERMS); n++) begin
            term = (term >> 1) / 64'(n);
            if ((n % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        half = pos - neg;
        sq   = half * half;
        return sq[63:32];
    endfunction

endpackage

/* src/hfg_dist.sv */
`timescale 1ns / 1ps
// Squared distance from the plane centre, scaled by the slope.
// Three register stages; uses hfg_pkg.
module hfg_dist
    import hfg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [9:0]           i_row,
    input  logic [9:0]           i_col,
    input  logic [9:0]           i_row_ctr,
    input  logic [9:0]           i_col_ctr,
    input  logic [4:0]           i_slope,
    output logic                 o_vld,
    output logic [HFG_NUM_W-1:0] o_num
);

    logic                 r_a_vld, r_b_vld, r_c_vld;
    logic [9:0]           r_a_dr, r_a_dc, n_a_dr, n_a_dc;
    logic [19:0]          r_b_sr, r_b_sc;
    logic [HFG_NUM_W-1:0] r_c_num;
    logic [20:0]          w_sum;

    always_comb begin
        n_a_dr = (i_row >= i_row_ctr) ? (i_row - i_row_ctr) : (i_row_ctr - i_row);
        n_a_dc = (i_col >= i_col_ctr) ? (i_col - i_col_ctr) : (i_col_ctr - i_col);
    end

    assign w_sum = {1'b0, r_b_sr} + {1'b0, r_b_sc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dr  <= n_a_dr;
            r_a_dc  <= n_a_dc;
            r_b_sr  <= r_a_dr * r_a_dr;
            r_b_sc  <= r_a_dc * r_a_dc;
            r_c_num <= HFG_NUM_W'(w_sum) * HFG_NUM_W'(i_slope);
        end
    end

    assign o_vld = r_c_vld;
    assign o_num = r_c_num;

endmodule

/* src/hfg_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: (num << 32) / den, four quotient bits a stage.
// Uses hfg_pkg.
module hfg_div
    import hfg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [HFG_NUM_W-1:0] i_num,
    input  logic [HFG_DEN_W-1:0] i_den,
    output logic                 o_vld,
    output logic [HFG_QUO_W-1:0] o_quo
);

    localparam int unsigned STAGES = (HFG_QUO_W + HFG_DIV_STEP - 1) / HFG_DIV_STEP;
    localparam int unsigned PAD_W  = STAGES * HFG_DIV_STEP;

    logic                 w_vld [STAGES+1];
    logic [HFG_DEN_W-1:0] w_rem [STAGES+1];
    logic [PAD_W-1:0]     w_dvd [STAGES+1];
    logic [PAD_W-1:0]     w_quo [STAGES+1];

    assign w_vld[0] = i_vld;
    assign w_rem[0] = '0;
    assign w_dvd[0] = {{(PAD_W-HFG_QUO_W){1'b0}}, i_num, {HFG_FRAC_W{1'b0}}};
    assign w_quo[0] = '0;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic                 r_vld;
        logic [HFG_DEN_W-1:0] r_rem, n_rem;
        logic [PAD_W-1:0]     r_dvd, n_dvd;
        logic [PAD_W-1:0]     r_quo, n_quo;

        always_comb begin
            logic [HFG_DEN_W:0] trial;
            n_rem = w_rem[s];
            n_dvd = w_dvd[s];
            n_quo = w_quo[s];
            for (int b = 0; b < int'(HFG_DIV_STEP); b++) begin
                trial = {n_rem, n_dvd[PAD_W-1]};
                n_dvd = {n_dvd[PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, i_den}) begin
                    n_rem = HFG_DEN_W'(trial - {1'b0, i_den});
                    n_quo = {n_quo[PAD_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[HFG_DEN_W-1:0];
                    n_quo = {n_quo[PAD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_dvd <= n_dvd;
                r_quo <= n_quo;
            end
        end

        assign w_vld[s+1] = r_vld;
        assign w_rem[s+1] = r_rem;
        assign w_dvd[s+1] = r_dvd;
        assign w_quo[s+1] = r_quo;
    end

    assign o_vld = w_vld[STAGES];
    assign o_quo = w_quo[STAGES][HFG_QUO_W-1:0];

endmodule

/* src/hfg_term.sv */
`timescale 1ns / 1ps
// One term of the exp(-f) series: term * f, then divide by N via reciprocal.
// Two register stages; uses hfg_pkg.
module hfg_term
    import hfg_pkg::*;
#(
    parameter int unsigned N = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_ser i_st,
    output t_ser o_st
);

    localparam int unsigned SH      = 32 + $clog2(N);
    localparam logic [32:0] MAGIC   = 33'(((64'd1 << SH) + 64'(N) - 64'd1) / 64'(N));
    localparam bit          ADD_POS = ((N - 1) % 2) == 0;

    t_ser        r_p, n_p, r_d, n_d;
    logic [64:0] w_prod;
    logic [65:0] w_recip;

    // previous term joins its sum in parallel with the multiply
    always_comb begin
        w_prod   = 65'(i_st.term) * 65'(i_st.f);
        n_p      = i_st;
        n_p.term = 33'(w_prod >> 32);
        if (ADD_POS) begin
            n_p.pos = i_st.pos + 35'(i_st.term);
        end else begin
            n_p.neg = i_st.neg + 34'(i_st.term);
        end
    end

    always_comb begin
        w_recip  = 66'(r_p.term[31:0]) * 66'(MAGIC);
        n_d      = r_p;
        n_d.term = 33'(w_recip >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.vld <= 1'b0;
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_p <= n_p;
            r_d <= n_d;
        end
    end

    assign o_st = r_d;

endmodule

/* src/hfg_exp.sv */
`timescale 1ns / 1ps
// exp(-x) rounded to unsigned Q1.16 from the divider quotient.
// Series stages (hfg_term), exp(-1) power stages, rounding; uses hfg_pkg.
module hfg_exp
    import hfg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [HFG_QUO_W-1:0] i_quo,
    output logic                 o_vld,
    output logic [16:0]          o_e
);

    localparam logic [31:0] E1 = f_exp_neg_one();

    t_ser        w_ser [HFG_SER_TERMS+1];
    t_ser        r_acc, n_acc;
    t_pow        w_pow [HFG_POW_STAGES+1];
    t_pow        r_sub, n_sub;
    logic        r_rnd_vld;
    logic [16:0] r_rnd_e, n_rnd_e;

    always_comb begin
        w_ser[0].vld  = i_vld;
        w_ser[0].big  = i_quo[HFG_QUO_W-1:HFG_FRAC_W] >= (HFG_NUM_W)'(HFG_ZERO_LIMIT);
        w_ser[0].k    = i_quo[HFG_FRAC_W+3:HFG_FRAC_W];
        w_ser[0].f    = i_quo[HFG_FRAC_W-1:0];
        w_ser[0].term = 33'h1_0000_0000;
        w_ser[0].pos  = '0;
        w_ser[0].neg  = '0;
    end

    for (genvar n = 1; n <= HFG_SER_TERMS; n++) begin : g_term
        hfg_term #(.N(n)) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_st    (w_ser[n-1]),
            .o_st    (w_ser[n])
        );
    end

    // last term has an even index
    always_comb begin
        n_acc     = w_ser[HFG_SER_TERMS];
        n_acc.pos = w_ser[HFG_SER_TERMS].pos + 35'(w_ser[HFG_SER_TERMS].term);
    end

    always_comb begin
        n_sub.vld = r_acc.vld;
        n_sub.big = r_acc.big;
        n_sub.k   = r_acc.k;
        n_sub.e   = 33'(r_acc.pos - 35'(r_acc.neg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.vld <= 1'b0;
            r_sub.vld <= 1'b0;
        end else if (i_en) begin
            r_acc <= n_acc;
            r_sub <= n_sub;
        end
    end

    assign w_pow[0] = r_sub;

    for (genvar i = 0; i < HFG_POW_STAGES; i++) begin : g_pow
        t_pow        r_st, n_st;
        logic [64:0] w_prod;

        always_comb begin
            w_prod = 65'(w_pow[i].e) * 65'(E1);
            n_st   = w_pow[i];
            if (w_pow[i].k > 4'(i)) begin
                n_st.e = 33'(w_prod >> 32);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st.vld <= 1'b0;
            end else if (i_en) begin
                r_st <= n_st;
            end
        end

        assign w_pow[i+1] = r_st;
    end

    always_comb begin
        if (w_pow[HFG_POW_STAGES].big) begin
            n_rnd_e = '0;
        end else begin
            n_rnd_e = 17'((w_pow[HFG_POW_STAGES].e + 33'h8000) >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
        end else if (i_en) begin
            r_rnd_vld <= w_pow[HFG_POW_STAGES].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd_e <= n_rnd_e;
        end
    end

    assign o_vld = r_rnd_vld;
    assign o_e   = r_rnd_e;

endmodule

/* src/homomorphic_filter_gain_core.sv */
`timescale 1ns / 1ps
// Gaussian high-emphasis homomorphic filter gain, one coefficient per request.
// Top level; uses hfg_pkg, hfg_dist, hfg_div, hfg_exp.
//
// Slave stream: one request carries a frequency-plane coordinate (row, col).
// Master stream: one result per request, the gain in unsigned Q5.11, in order.
// Config channel: register writes by index, always ready; write only while idle.
// Pipeline from request accept to result valid: 3 distance stages, 15 divider
// stages, 32 series stages, 2 sum stages, 11 exp(-1) power stages, rounding,
// gain mix, output register.
// Throughput: one request per cycle unless stalled; the single enable sets it.
// Reset: registers return to their defaults (cutoff 5, plane 1024 x 1024,
// gains and slope 0); the pipeline empties.
// Stall: a result the receiver does not take parks in a skid register; the
// pipeline then holds and s_axis_tready drops until the skid empties. Nothing
// is lost or repeated.
module homomorphic_filter_gain_core
    import hfg_pkg::*;
#(
    parameter int unsigned MAX_DIM        = HFG_MAX_DIM,
    parameter int unsigned GAIN_FRAC_BITS = HFG_GAIN_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] row_index, [19:10] col_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] gain
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int unsigned SHIFT = 16 - GAIN_FRAC_BITS;
    localparam logic [22:0] RND   = 23'((2 ** SHIFT) / 2);

    logic [4:0]  r_gamma_high, r_gamma_low, r_slope;
    logic [5:0]  r_cutoff;
    logic [10:0] r_rows, r_cols;

    logic                 w_en;
    logic                 w_dist_vld, w_div_vld, w_exp_vld;
    logic [HFG_NUM_W-1:0] w_num;
    logic [HFG_QUO_W-1:0] w_quo;
    logic [HFG_DEN_W-1:0] w_den;
    logic [16:0]          w_e;
    logic [22:0]          w_mix, w_rnd;

    logic        r_g_vld;
    logic [15:0] r_g_gain, n_g_gain;
    logic        r_out_vld, n_out_vld, r_skid_vld, n_skid_vld;
    logic [15:0] r_out, n_out, r_skid, n_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_high <= '0;
            r_gamma_low  <= '0;
            r_cutoff     <= 6'd5;
            r_slope      <= '0;
            r_rows       <= 11'd1024;
            r_cols       <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GAMMA_HIGH: begin
                    r_gamma_high <= i_cfg_data[4:0];
                end
                CFG_GAMMA_LOW: begin
                    r_gamma_low <= i_cfg_data[4:0];
                end
                CFG_CUTOFF_RADIUS: begin
                    r_cutoff <= (i_cfg_data[5:0] == 6'd0) ? 6'd1 : i_cfg_data[5:0];
                end
                CFG_SLOPE: begin
                    r_slope <= i_cfg_data[4:0];
                end
                CFG_PLANE_ROWS: begin
                    r_rows <= ({2'b0, i_cfg_data} > 13'(MAX_DIM)) ? 11'(MAX_DIM) : i_cfg_data;
                end
                CFG_PLANE_COLS: begin
                    r_cols <= ({2'b0, i_cfg_data} > 13'(MAX_DIM)) ? 11'(MAX_DIM) : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_en          = ~r_skid_vld;
    assign s_axis_tready = w_en;
    assign w_den         = 12'(r_cutoff) * 12'(r_cutoff);

    hfg_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (s_axis_tvalid),
        .i_row     (s_axis_tdata[9:0]),
        .i_col     (s_axis_tdata[19:10]),
        .i_row_ctr (r_rows[10:1]),
        .i_col_ctr (r_cols[10:1]),
        .i_slope   (r_slope),
        .o_vld     (w_dist_vld),
        .o_num     (w_num)
    );

    hfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dist_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo)
    );

    hfg_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_quo   (w_quo),
        .o_vld   (w_exp_vld),
        .o_e     (w_e)
    );

    // H = gamma_high * (1 - E) + gamma_low * E, in Q16
    always_comb begin
        w_mix = 23'(r_gamma_high) * 23'(17'h1_0000 - w_e) + 23'(r_gamma_low) * 23'(w_e);
        w_rnd = (w_mix + RND) >> SHIFT;
        n_g_gain = (w_rnd > 23'hFFFF) ? 16'hFFFF : w_rnd[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_g_vld <= w_exp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_gain <= n_g_gain;
        end
    end

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (r_skid_vld) begin
            if (r_out_vld && m_axis_tready) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end
        end else if (r_g_vld) begin
            if (!r_out_vld || m_axis_tready) begin
                n_out     = r_g_gain;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = r_g_gain;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

/* src/hfg_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of homomorphic_filter_gain_core, bound to the top level.
// Uses homomorphic_filter_gain_core_macros.svh.
`include "homomorphic_filter_gain_core_macros.svh"

module hfg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    `HFG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `HFG_ASSERT(a_ready_drop, !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready), "input stalled without an output stall")
    `HFG_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result valid straight after reset")
    `HFG_ASSERT(a_cfg_ready, i_cfg_valid |-> o_cfg_ready, "config write refused")

endmodule

bind homomorphic_filter_gain_core hfg_checker u_hfg_checker (.*);

/* dv/homomorphic_filter_gain_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for homomorphic_filter_gain_core: random coordinate
// requests under several register settings, checked against a local gain model.
// Depends on hfg_pkg and the core RTL only.
module homomorphic_filter_gain_core_tb;
    import hfg_pkg::*;

    localparam logic [2:0] CFG_SPARE_A = 3'd6;   // not decoded by the core
    localparam logic [2:0] CFG_SPARE_B = 3'd7;
    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES   = 80;

    // gain predictor and queue of expected gains
    class gain_scoreboard;
        bit [4:0]  gamma_high, gamma_low, slope;
        bit [5:0]  cutoff;
        bit [10:0] rows, cols;
        bit [63:0] exp_m1;
        bit [15:0] gain_q[$];
        int        errors, n_req, n_res;

        function new();
            bit [63:0] half;
            gamma_high = 0; gamma_low = 0; slope = 0; cutoff = 5;
            rows = 1024; cols = 1024;
            half = exp_frac(64'h8000_0000);
            exp_m1 = (half * half) >> 32;
        endfunction

        function bit [63:0] exp_frac(bit [63:0] f);
            bit [63:0] term, pos, neg;
            term = 64'h1_0000_0000; pos = term; neg = 0;
            for (int n = 1; n <= 16; n++) begin
                term = ((term * f) >> 32) / 64'(n);
                if (n % 2) neg += term;
                else pos += term;
            end
            return pos - neg;
        endfunction

        function void write(t_cfg_index idx, bit [10:0] val);
            case (idx)
                CFG_GAMMA_HIGH:    gamma_high = val[4:0];
                CFG_GAMMA_LOW:     gamma_low  = val[4:0];
                CFG_CUTOFF_RADIUS: cutoff = (val[5:0] == 0) ? 6'd1 : val[5:0];
                CFG_SLOPE:         slope = val[4:0];
                CFG_PLANE_ROWS:    rows = (val > 1024) ? 11'd1024 : val;
                CFG_PLANE_COLS:    cols = (val > 1024) ? 11'd1024 : val;
                default: ;
            endcase
        endfunction

        function void note(bit [9:0] row, bit [9:0] col);
            longint dr, dc;
            bit [63:0] dist2, x, k, e, h;
            dr = longint'(row) - longint'(rows / 2);
            dc = longint'(col) - longint'(cols / 2);
            dist2 = 64'(dr * dr + dc * dc);
            x = ((64'(slope) * dist2) << 32) / (64'(cutoff) * 64'(cutoff));
            k = x >> 32;
            if (k >= 12) begin
                e = 0;
            end else begin
                e = exp_frac({32'd0, x[31:0]});
                for (int i = 0; i < int'(k); i++) e = (e * exp_m1) >> 32;
                e = (e + 64'h8000) >> 16;
            end
            h = 64'(gamma_high) * (64'h10000 - e) + 64'(gamma_low) * e;
            h = (h + 64'd16) >> 5;
            if (h > 64'hFFFF) h = 64'hFFFF;
            gain_q = {gain_q, h[15:0]};
            n_req++;
        endfunction

        function void check(bit [15:0] gain);
            bit [15:0] want;
            n_res++;
            if (gain_q.size() == 0) begin
                $error("gain: unexpected result %0d", gain);
                errors++;
                return;
            end
            want = gain_q.pop_front();
            if (want !== gain) begin
                $error("gain: expected %0d, actual %0d", want, gain);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    gain_scoreboard sb = new();
    bit          no_idle = 1'b0;
    int unsigned cycles = 0;
    int          n_cfg = 0;

    homomorphic_filter_gain_core u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("homomorphic_filter_gain_core_tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
            if (s_axis_tvalid && s_axis_tready)
                sb.note(s_axis_tdata[9:0], s_axis_tdata[19:10]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata);
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [10:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write(t_cfg_index'(idx), val);
        n_cfg++;
    endtask

    task automatic send(bit [9:0] row, bit [9:0] col);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained(bit settle);
        s_axis_tvalid <= 1'b0;
        while (sb.gain_q.size() != 0) @(posedge i_clk);
        if (settle) repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs(bit [4:0] gh, bit [4:0] gl, bit [5:0] cut, bit [4:0] slp,
                             bit [10:0] nr, bit [10:0] nc);
        cfg_write(CFG_GAMMA_HIGH, 11'(gh));
        cfg_write(CFG_GAMMA_LOW, 11'(gl));
        cfg_write(CFG_CUTOFF_RADIUS, 11'(cut));
        cfg_write(CFG_SLOPE, 11'(slp));
        cfg_write(CFG_PLANE_ROWS, nr);
        cfg_write(CFG_PLANE_COLS, nc);
        cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 11'($urandom));
    endtask

    function automatic bit [9:0] near(int centre, int span);
        int v;
        v = centre + $urandom_range(2 * span) - span;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return 10'(v);
    endfunction

    initial begin
        int span;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults straight out of reset
        send(10'd0, 10'd0);
        send(10'd512, 10'd512);
        send(10'd1023, 10'd1023);
        wait_drained(1'b1);

        // zero cutoff stores one, strong slope
        load_regs(5'd25, 5'd0, 6'd0, 5'd20, 11'd1024, 11'd1024);
        send(10'd512, 10'd512);
        send(10'd512, 10'd513);
        send(10'd513, 10'd513);
        send(10'd514, 10'd512);
        send(10'd0, 10'd0);
        send(10'd1023, 10'd0);
        send(10'd0, 10'd1023);
        send(10'd1023, 10'd1023);
        wait_drained(1'b1);
        // gamma_high below gamma_low, oversized and tiny planes, full-width fields
        load_regs(5'd2, 5'd31, 6'd63, 5'd31, 11'd2047, 11'd1);
        for (int i = 0; i < 6; i++) send(near(512, 40), near(0, 40));
        send(10'd1023, 10'd1023);
        wait_drained(1'b1);
        load_regs(5'd31, 5'd31, 6'd1, 5'd1, 11'd0, 11'd1025);
        send(10'd0, 10'd512);
        send(10'd1, 10'd511);
        send(10'd1023, 10'd0);
        wait_drained(1'b1);

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: load_regs(5'd25, 5'd0, 6'd60, 5'd20, 11'd1024, 11'd1024);
                1: load_regs(5'd0, 5'd25, 6'd1, 5'd0, 11'd2, 11'd2);
                2: load_regs(5'd3, 5'd20, 6'd8, 5'd5, 11'd64, 11'd100);
                default: load_regs(5'($urandom), 5'($urandom), 6'($urandom), 5'($urandom),
                                   11'($urandom), 11'($urandom));
            endcase
            no_idle = (p == 4);
            span = 3 * int'(sb.cutoff) + 2;
            for (int i = 0; i < 165; i++) begin
                if (p == 3 && i == 80) wait_drained(1'b0);
                if ($urandom_range(99) < 70)
                    send(near(int'(sb.rows / 2), span), near(int'(sb.cols / 2), span));
                else
                    send(10'($urandom), 10'($urandom));
            end
            wait_drained(1'b1);
        end
        no_idle = 1'b0;

        $display("%0d coordinate requests over %0d register writes, %0d gains checked",
                 sb.n_req, n_cfg, sb.n_res);
        $display("settings covered gain extremes, inverted gains and clamped plane sizes");
        if (sb.errors == 0 && sb.gain_q.size() == 0) begin
            $display("homomorphic_filter_gain_core_tb OK");
        end else begin
            $display("homomorphic_filter_gain_core_tb NOT OK");
        end
        $finish;
    end

endmodule
